@@ rtl/core/block_request_coalescer_top_defines.svh @@
// Assertion macros for the block request coalescer.
`ifndef BLOCK_REQUEST_COALESCER_TOP_DEFINES_SVH
`define BLOCK_REQUEST_COALESCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BRC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define BRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define BRC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/bkc_pkg.sv @@
`default_nettype none

package bkc_pkg;

    localparam int MAX_BATCH   = 64;
    localparam int OFFSET_BITS = 48;

    localparam int ID_W       = 7;
    localparam int BLOCKS_W   = 16;
    localparam int SHIFT_W    = 5;
    localparam int LIMIT_W    = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int RUN_BYTES_W = BLOCKS_W + (1 << SHIFT_W) - 1;

    localparam int ID_CAP_INT = (MAX_BATCH > 127) ? 127 : ((MAX_BATCH < 1) ? 1 : MAX_BATCH);
    localparam logic [ID_W-1:0] ID_CAP = ID_W'(ID_CAP_INT);
    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

    localparam logic [BLOCKS_W-1:0] RUN_MAX = {BLOCKS_W{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET  = 2'd2;

    localparam logic [SHIFT_W-1:0] SIZE_SHIFT_RST  = 5'd12;
    localparam logic [LIMIT_W-1:0] MERGE_LIMIT_RST = '0;
    localparam logic [LIMIT_W-1:0] MAX_PACKET_RST  = 25'd131072;

    typedef struct packed {
        logic [SHIFT_W-1:0] size_shift;
        logic [LIMIT_W-1:0] merge_limit_bytes;
        logic [LIMIT_W-1:0] max_packet_bytes;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic [OFFSET_BITS-1:0] offset;
        logic [BLOCKS_W-1:0]    blocks;
        logic                   final_req;
    } req_t;

    typedef struct packed {
        logic vld0;
        logic vld1;
        req_t req0;
        req_t req1;
    } push_t;

    typedef struct packed {
        logic              room;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/bkc_run.sv @@
`default_nettype none

module bkc_run
    import bkc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [OFFSET_BITS-1:0] block_offset,
    input  wire logic                   batch_end,
    input  wire cfg_t                   cfg,
    input  wire q_stat_t                q_stat,
    output push_t                       push
);

    logic                   stage_vld_reg;
    logic                   stage_vld_next;
    logic [OFFSET_BITS-1:0] stage_offset_reg;
    logic                   stage_last_reg;

    logic [OFFSET_BITS-1:0] run_start_reg;
    logic [OFFSET_BITS-1:0] run_start_next;
    logic [BLOCKS_W-1:0]    run_length_reg;
    logic [BLOCKS_W-1:0]    run_length_next;
    logic                   run_open_reg;
    logic                   run_open_next;
    logic [ID_W-1:0]        id_reg;
    logic [ID_W-1:0]        id_next;

    logic                   accept;
    logic                   go;
    logic [LIMIT_W-1:0]     limit;
    logic [RUN_BYTES_W-1:0] run_bytes;
    logic [OFFSET_BITS:0]   next_addr;
    logic                   join_run;
    logic                   emit_open;
    logic [ID_W-1:0]        id_after;
    logic [OFFSET_BITS-1:0] new_start;
    logic [BLOCKS_W-1:0]    new_length;
    req_t                   open_req;
    req_t                   last_req;

    assign go       = stage_vld_reg && q_stat.room;
    assign in_stall = stage_vld_reg && !q_stat.room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        stage_vld_next = stage_vld_reg;
        if (accept)
        begin
            stage_vld_next = 1'b1;
        end
        else if (go)
        begin
            stage_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= stage_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_offset_reg <= block_offset;
            stage_last_reg   <= batch_end;
        end
    end

    assign limit = (cfg.merge_limit_bytes != '0) ? cfg.merge_limit_bytes
                                                  : cfg.max_packet_bytes;
    assign run_bytes = RUN_BYTES_W'(run_length_reg) << cfg.size_shift;
    assign next_addr = {1'b0, run_start_reg} + (OFFSET_BITS + 1)'(run_bytes);

    assign join_run = run_open_reg
                   && ({1'b0, stage_offset_reg} == next_addr)
                   && (run_bytes < RUN_BYTES_W'(limit))
                   && (run_length_reg != RUN_MAX);
    assign emit_open = run_open_reg && !join_run;

    assign id_after = (emit_open && (id_reg < ID_CAP)) ? id_reg + ID_W'(1) : id_reg;

    assign new_start  = join_run ? run_start_reg : stage_offset_reg;
    assign new_length = join_run ? run_length_reg + BLOCKS_W'(1) : BLOCKS_W'(1);

    always_comb
    begin
        open_req.id        = id_reg;
        open_req.offset    = run_start_reg;
        open_req.blocks    = run_length_reg;
        open_req.final_req = 1'b0;

        last_req.id        = id_after;
        last_req.offset    = new_start;
        last_req.blocks    = new_length;
        last_req.final_req = 1'b1;

        push.vld0 = go && (emit_open || stage_last_reg);
        push.vld1 = go && emit_open && stage_last_reg;
        push.req0 = emit_open ? open_req : last_req;
        push.req1 = last_req;
    end

    always_comb
    begin
        run_start_next  = run_start_reg;
        run_length_next = run_length_reg;
        run_open_next   = run_open_reg;
        id_next         = id_reg;
        if (go)
        begin
            if (stage_last_reg)
            begin
                run_start_next  = '0;
                run_length_next = '0;
                run_open_next   = 1'b0;
                id_next         = ID_FIRST;
            end
            else
            begin
                run_start_next  = new_start;
                run_length_next = new_length;
                run_open_next   = 1'b1;
                id_next         = id_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg  <= '0;
            run_length_reg <= '0;
            run_open_reg   <= 1'b0;
            id_reg         <= ID_FIRST;
        end
        else
        begin
            run_start_reg  <= run_start_next;
            run_length_reg <= run_length_next;
            run_open_reg   <= run_open_next;
            id_reg         <= id_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bkc_queue.sv @@
`default_nettype none

module bkc_queue
    import bkc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output q_stat_t    q_stat,
    output logic       out_valid,
    input  wire logic  out_stall,
    output req_t       head
);

    req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;
    logic [QPTR_W-1:0] wr_ptr_plus1;

    assign out_valid    = (count_reg != '0);
    assign pop          = out_valid && !out_stall;
    assign head         = entry_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);

    assign q_stat.count = count_reg;
    assign q_stat.room  = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.vld0) + QPTR_W'(push.vld1);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.vld0) + QCNT_W'(push.vld1) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.vld0)
        begin
            entry_reg[wr_ptr_reg] <= push.req0;
        end
        if (push.vld1)
        begin
            entry_reg[wr_ptr_plus1] <= push.req1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/block_request_coalescer_top.sv @@
// An offset is taken into an input register when accepted and is merged into the open run
// once the output queue has room; its requests then enter the queue and appear at the outputs.
// One offset is accepted per cycle while the four-entry queue holds at most two requests;
// an offset that closes a run and ends a batch yields two requests, drained one per cycle while out_stall is low.
// Reset clears the open run, restarts request numbering at 1, empties the queue, and sets
// the registers to block size shift 12, merge limit 0 and packet limit 131072.
`default_nettype none
`include "block_request_coalescer_top_defines.svh"

module block_request_coalescer_top
    import bkc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [OFFSET_BITS-1:0] block_offset,
    input  wire logic                   batch_end,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [ID_W-1:0]             request_id,
    output logic [OFFSET_BITS-1:0]      request_offset,
    output logic [BLOCKS_W-1:0]         request_blocks,
    output logic                        final_request,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [LIMIT_W-1:0]     cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    push_t   push;
    q_stat_t q_stat;
    req_t    head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIZE_SHIFT:  cfg_next.size_shift        = cfg_data[SHIFT_W-1:0];
                CFG_MERGE_LIMIT: cfg_next.merge_limit_bytes = cfg_data;
                CFG_MAX_PACKET:  cfg_next.max_packet_bytes  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_shift        <= SIZE_SHIFT_RST;
            cfg_reg.merge_limit_bytes <= MERGE_LIMIT_RST;
            cfg_reg.max_packet_bytes  <= MAX_PACKET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bkc_run u_run (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .block_offset (block_offset),
        .batch_end    (batch_end),
        .cfg          (cfg_reg),
        .q_stat       (q_stat),
        .push         (push)
    );

    bkc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_stat    (q_stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign request_id     = head.id;
    assign request_offset = head.offset;
    assign request_blocks = head.blocks;
    assign final_request  = head.final_req;

    `BRC_ASSERT_IMPLIES(a_queue_bound, clk, rst_n, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    `BRC_ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, !q_stat.room)
    `BRC_ASSERT_IMPLIES(a_id_range, clk, rst_n, out_valid, (request_id != '0) && (request_id <= ID_CAP))
    `BRC_ASSERT_IMPLIES(a_blocks_nonzero, clk, rst_n, out_valid, request_blocks != '0)

endmodule

`default_nettype wire
